// File: sv/ost_pkg.sv
// shared types, codes and widths for the ordered sequence table
package ost_pkg;

    localparam int KIND_W          = 3;
    localparam int POS_W           = 6;
    localparam int ITEM_W          = 32;
    localparam int IDX_W           = 5;
    localparam int CNT_W           = 6;
    localparam int LIMIT_W         = 6;
    localparam int LOOK_N          = 2 ** POS_W;
    localparam int DEF_CAPACITY    = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int APB_WORD_W = APB_ADDR_W - 2;

    localparam logic [APB_WORD_W-1:0] REG_LIMIT_IDX = APB_WORD_W'(0);
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET   = LIMIT_W'(32);

    typedef enum logic [KIND_W-1:0] {
        K_INSERT_AT     = 3'd0,
        K_INSERT_SORTED = 3'd1,
        K_ERASE         = 3'd2,
        K_REMOVE_ALL    = 3'd3,
        K_FIND          = 3'd4,
        K_GET           = 3'd5,
        K_SET           = 3'd6,
        K_NOP           = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE,
        CELL_WRITE
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [POS_W-1:0] pos;
    } cell_cmd_t;

    typedef struct packed {
        logic eq;
        logic ge;
    } cell_flags_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN_UP,
        ST_SCAN_DOWN
    } state_t;

endpackage

// File: sv/ost_in_if.sv
// request channel: one list operation per beat
interface ost_in_if;
    import ost_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [ITEM_W-1:0] item_value;

    modport source (output valid, kind, position, item_value, input ready);
    modport sink   (input valid, kind, position, item_value, output ready);
endinterface

// File: sv/ost_out_if.sv
// response channel: one result per operation
interface ost_out_if;
    import ost_pkg::*;

    logic              valid;
    logic              ready;
    logic              ok;
    logic [IDX_W-1:0]  result_index;
    logic [CNT_W-1:0]  removed_count;
    logic [ITEM_W-1:0] read_value;
    logic [CNT_W-1:0]  entry_count;

    modport source (output valid, ok, result_index, removed_count, read_value, entry_count,
                    input ready);
    modport sink   (input valid, ok, result_index, removed_count, read_value, entry_count,
                    output ready);
endinterface

// File: sv/ordered_sequence_table_top.sv
// top level of the ordered sequence table
//
//   channel  dir  handshake         carries
//   req      in   valid/ready       kind, position, item_value
//   rsp      out  valid/ready       ok, result_index, removed_count, read_value, entry_count
//   apb      in   psel/penable      capacity_limit at byte address 0
//
// insert_at, erase, get, set, the unused kind and insert_sorted on a full list
// are answered from the idle state without a scan
// find and insert_sorted scan upward from position 0 to the first matching position
// (or to the count when nothing matches); remove_all scans down, answering at once when empty
// the scans visit one cell per cycle through the row's single lookup port
// no clearing pass after reset: entries are never read at or beyond the count
// a response held by rsp stall blocks the next req beat until it drains
module ordered_sequence_table_top #(
    parameter int CAPACITY    = ost_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = ost_pkg::DEF_VALUE_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ost_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ost_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ost_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    ost_in_if.sink                         req,
    ost_out_if.source                      rsp
);
    import ost_pkg::*;

    logic [LIMIT_W-1:0]     limit;
    cell_cmd_t              cmd;
    logic [VALUE_WIDTH-1:0] value;
    logic [VALUE_WIDTH-1:0] rd_entry;
    cell_flags_t            flags;

    ost_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limit   (limit)
    );

    ost_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .limit    (limit),
        .cmd      (cmd),
        .value    (value),
        .rd_entry (rd_entry),
        .flags    (flags)
    );

    ost_cell_row #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_row (
        .clk      (clk),
        .cmd      (cmd),
        .value    (value),
        .rd_entry (rd_entry),
        .flags    (flags)
    );

`ifndef SYNTHESIS
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ok) |-> ((rsp.result_index == '0) && (rsp.read_value == '0)))
        else $error("failed beat carries a nonzero index or read value");

    a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.removed_count != '0)) |-> rsp.ok)
        else $error("removal count reported without success");

    a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == CELL_WRITE) |-> (req.valid && req.ready))
        else $error("cell write outside an accepted set beat");

    a_insert_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == CELL_INSERT) |=> (rsp.valid && rsp.ok))
        else $error("insert into the row without a successful response");
`endif
endmodule

// File: sv/ost_cell.sv
// one list slot: holds an entry, shifts with its neighbors, compares against the key
module ost_cell #(
    parameter int VALUE_WIDTH = ost_pkg::DEF_VALUE_WIDTH,
    parameter int INDEX       = 0
) (
    input  logic                   clk,
    input  ost_pkg::cell_cmd_t     cmd,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [VALUE_WIDTH-1:0] left_entry,
    input  logic [VALUE_WIDTH-1:0] right_entry,
    output logic [VALUE_WIDTH-1:0] entry,
    output ost_pkg::cell_flags_t   flags
);
    import ost_pkg::*;

    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;
    logic                   at_pos;
    logic                   above_pos;

    assign at_pos    = (32'(cmd.pos) == 32'(INDEX));
    assign above_pos = (32'(INDEX) > 32'(cmd.pos));

    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.op)
            CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            CELL_INSERT:
            begin
                if (at_pos)
                begin
                    entry_next = value;
                end
                else if (above_pos)
                begin
                    entry_next = left_entry;
                end
            end
            CELL_ERASE:
            begin
                if (at_pos || above_pos)
                begin
                    entry_next = right_entry;
                end
            end
            CELL_WRITE:
            begin
                if (at_pos)
                begin
                    entry_next = value;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry    = entry_reg;
    assign flags.eq = (entry_reg == value);
    assign flags.ge = (entry_reg >= value);
endmodule

// File: sv/ost_cell_row.sv
// chain of list cells with the lookup of one position
module ost_cell_row #(
    parameter int CAPACITY    = ost_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = ost_pkg::DEF_VALUE_WIDTH
) (
    input  logic                   clk,
    input  ost_pkg::cell_cmd_t     cmd,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic [VALUE_WIDTH-1:0] rd_entry,
    output ost_pkg::cell_flags_t   flags
);
    import ost_pkg::*;

    logic [VALUE_WIDTH-1:0] entry_w [CAPACITY];
    cell_flags_t            flags_w [CAPACITY];
    logic [VALUE_WIDTH-1:0] look_entry [LOOK_N];
    cell_flags_t            look_flags [LOOK_N];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_w;
        logic [VALUE_WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_head
            assign left_w = value;
        end
        else
        begin : g_link_left
            assign left_w = entry_w[i-1];
        end

        // last cell refills from itself, that slot is past the end anyway
        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_w = entry_w[i];
        end
        else
        begin : g_link_right
            assign right_w = entry_w[i+1];
        end

        ost_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .INDEX       (i)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .value       (value),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entry_w[i]),
            .flags       (flags_w[i])
        );
    end

    // positions reachable by the 6-bit index, padded past the last cell
    for (genvar k = 0; k < LOOK_N; k++)
    begin : g_look
        if (k < CAPACITY)
        begin : g_real
            assign look_entry[k] = entry_w[k];
            assign look_flags[k] = flags_w[k];
        end
        else
        begin : g_pad
            assign look_entry[k] = '0;
            assign look_flags[k] = '0;
        end
    end

    assign rd_entry = look_entry[cmd.pos];
    assign flags    = look_flags[cmd.pos];
endmodule

// File: sv/ost_cfg.sv
// apb register block holding the capacity limit
module ost_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ost_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ost_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ost_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [ost_pkg::LIMIT_W-1:0]    limit
);
    import ost_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] limit_next;
    logic               hit_limit;
    logic               wr_en;

    assign hit_limit = (paddr[APB_ADDR_W-1:2] == REG_LIMIT_IDX);
    assign wr_en     = psel && penable && pwrite && hit_limit;

    always_comb
    begin
        limit_next = limit_reg;
        if (wr_en)
        begin
            limit_next = pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    assign prdata = hit_limit ? APB_DATA_W'(limit_reg) : '0;
    assign pready = 1'b1;
    assign limit  = limit_reg;
endmodule

// File: sv/ost_ctrl.sv
// operation sequencer: count, scans over the cell row, result register
module ost_ctrl #(
    parameter int CAPACITY    = ost_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = ost_pkg::DEF_VALUE_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ost_in_if.sink                      req,
    ost_out_if.source                   rsp,
    input  logic [ost_pkg::LIMIT_W-1:0] limit,
    output ost_pkg::cell_cmd_t          cmd,
    output logic [VALUE_WIDTH-1:0]      value,
    input  logic [VALUE_WIDTH-1:0]      rd_entry,
    input  ost_pkg::cell_flags_t        flags
);
    import ost_pkg::*;

    localparam int               LIMIT_SPAN = 2 ** LIMIT_W;
    localparam bit               CAP_SMALL  = (CAPACITY < LIMIT_SPAN);
    localparam logic [CNT_W-1:0] CAP_CNT    =
        CNT_W'(CAPACITY < LIMIT_SPAN ? CAPACITY : LIMIT_SPAN - 1);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       j_reg, j_next;
    logic [CNT_W-1:0]       removed_reg, removed_next;
    kind_t                  kind_reg, kind_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;

    logic                   res_valid_reg, res_valid_next;
    logic                   res_ok_reg;
    logic [IDX_W-1:0]       res_idx_reg;
    logic [CNT_W-1:0]       res_removed_reg;
    logic [ITEM_W-1:0]      res_rd_reg;
    logic [CNT_W-1:0]       res_cnt_reg;

    logic                   res_load;
    logic                   ld_ok;
    logic [IDX_W-1:0]       ld_idx;
    logic [CNT_W-1:0]       ld_removed;
    logic [ITEM_W-1:0]      ld_rd;

    kind_t                  in_kind;
    logic [POS_W-1:0]       in_pos;
    logic [VALUE_WIDTH-1:0] in_val;
    logic [CNT_W-1:0]       usable;
    logic                   full;
    logic                   res_free;
    logic                   accept;
    logic                   at_end;
    logic                   up_hit;
    logic                   up_done;
    logic                   down_last;

    assign in_kind  = kind_t'(req.kind);
    assign in_pos   = req.position;
    assign in_val   = VALUE_WIDTH'(req.item_value);
    assign usable   = (CAP_SMALL && (limit > CAP_CNT)) ? CAP_CNT : limit;
    assign full     = (count_reg >= usable);
    assign res_free = !res_valid_reg || rsp.ready;
    assign accept   = req.valid && req.ready;

    assign at_end    = (j_reg == count_reg);
    assign up_hit    = !at_end && ((kind_reg == K_FIND) ? flags.eq : flags.ge);
    assign up_done   = at_end || up_hit;
    assign down_last = (j_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((in_kind == K_FIND) || ((in_kind == K_INSERT_SORTED) && !full))
                    begin
                        state_next = ST_SCAN_UP;
                    end
                    else if ((in_kind == K_REMOVE_ALL) && (count_reg != '0))
                    begin
                        state_next = ST_SCAN_DOWN;
                    end
                end
            end
            ST_SCAN_UP:
            begin
                if (up_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_DOWN:
            begin
                if (down_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        req.ready    = (state_reg == ST_IDLE) && res_free;
        cmd.op       = CELL_HOLD;
        cmd.pos      = (state_reg == ST_IDLE) ? in_pos : j_reg;
        value        = (state_reg == ST_IDLE) ? in_val : val_reg;
        count_next   = count_reg;
        j_next       = j_reg;
        removed_next = removed_reg;
        kind_next    = kind_reg;
        val_next     = val_reg;
        res_load     = 1'b0;
        ld_ok        = 1'b0;
        ld_idx       = '0;
        ld_removed   = '0;
        ld_rd        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next    = in_kind;
                    val_next     = in_val;
                    j_next       = '0;
                    removed_next = '0;
                    unique case (in_kind)
                        K_INSERT_AT:
                        begin
                            res_load = 1'b1;
                            if ((in_pos <= count_reg) && !full)
                            begin
                                cmd.op     = CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                                ld_ok      = 1'b1;
                                ld_idx     = in_pos[IDX_W-1:0];
                            end
                        end
                        K_INSERT_SORTED:
                        begin
                            res_load = full;
                        end
                        K_ERASE:
                        begin
                            res_load = 1'b1;
                            if (in_pos < count_reg)
                            begin
                                cmd.op     = CELL_ERASE;
                                count_next = count_reg - CNT_W'(1);
                                ld_ok      = 1'b1;
                            end
                        end
                        K_REMOVE_ALL:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load = 1'b1;
                                ld_ok    = 1'b1;
                            end
                            else
                            begin
                                j_next = count_reg - CNT_W'(1);
                            end
                        end
                        K_FIND:
                        begin
                            res_load = 1'b0;
                        end
                        K_GET:
                        begin
                            res_load = 1'b1;
                            if (in_pos < count_reg)
                            begin
                                ld_ok = 1'b1;
                                ld_rd = ITEM_W'(rd_entry);
                            end
                        end
                        K_SET:
                        begin
                            res_load = 1'b1;
                            if (in_pos < count_reg)
                            begin
                                cmd.op = CELL_WRITE;
                                ld_ok  = 1'b1;
                            end
                        end
                        K_NOP:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN_UP:
            begin
                if (up_done)
                begin
                    res_load = 1'b1;
                    if (kind_reg == K_INSERT_SORTED)
                    begin
                        // room was checked when the beat came in
                        cmd.op     = CELL_INSERT;
                        count_next = count_reg + CNT_W'(1);
                        ld_ok      = 1'b1;
                        ld_idx     = j_reg[IDX_W-1:0];
                    end
                    else if (up_hit)
                    begin
                        ld_ok  = 1'b1;
                        ld_idx = j_reg[IDX_W-1:0];
                    end
                end
                else
                begin
                    j_next = j_reg + CNT_W'(1);
                end
            end
            ST_SCAN_DOWN:
            begin
                // walking downward keeps lower positions stable under each erase
                if (flags.eq)
                begin
                    cmd.op       = CELL_ERASE;
                    count_next   = count_reg - CNT_W'(1);
                    removed_next = removed_reg + CNT_W'(1);
                end
                if (down_last)
                begin
                    res_load   = 1'b1;
                    ld_ok      = 1'b1;
                    ld_removed = removed_next;
                end
                else
                begin
                    j_next = j_reg - CNT_W'(1);
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase

        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            j_reg         <= '0;
            removed_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            j_reg         <= j_next;
            removed_reg   <= removed_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        val_reg  <= val_next;
        if (res_load)
        begin
            res_ok_reg      <= ld_ok;
            res_idx_reg     <= ld_idx;
            res_removed_reg <= ld_removed;
            res_rd_reg      <= ld_rd;
            res_cnt_reg     <= count_next;
        end
    end

    assign rsp.valid         = res_valid_reg;
    assign rsp.ok            = res_ok_reg;
    assign rsp.result_index  = res_idx_reg;
    assign rsp.removed_count = res_removed_reg;
    assign rsp.read_value    = res_rd_reg;
    assign rsp.entry_count   = res_cnt_reg;
endmodule

// File: bench/ordered_sequence_table_top_tb.sv
// self-checking testbench for the ordered sequence table top level
`timescale 1ns / 100ps

module ordered_sequence_table_top_tb;
    import ost_pkg::*;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 48;

    typedef struct {
        kind_t             kind;
        logic [POS_W-1:0]  position;
        logic [ITEM_W-1:0] item_value;
        bit                hold_first;
    } list_op_t;

    typedef struct {
        logic              ok;
        logic [IDX_W-1:0]  result_index;
        logic [CNT_W-1:0]  removed_count;
        logic [ITEM_W-1:0] read_value;
        logic [CNT_W-1:0]  entry_count;
    } list_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ost_in_if  req_if ();
    ost_out_if rsp_if ();

    ordered_sequence_table_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_if),
        .rsp     (rsp_if)
    );

    // shadow copy of the list and its limit
    logic [ITEM_W-1:0] list_vals [DEF_CAPACITY];
    int                list_len;
    int                limit_val;

    list_op_t     pending_ops [$];
    list_result_t due_results [$];
    list_op_t     cur_op;
    int           mismatch_n;
    int           cycle_n;
    int           gap_left;
    int           stall_left;
    bit           drive_burst;
    bit           take_burst;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic list_result_t apply_list_op(list_op_t op);
        list_result_t r;
        int           room;
        int           at;
        int           keep;
        int           i;
        r.ok            = 1'b0;
        r.result_index  = '0;
        r.removed_count = '0;
        r.read_value    = '0;
        room = (limit_val > DEF_CAPACITY) ? DEF_CAPACITY : limit_val;
        case (op.kind)
            K_INSERT_AT, K_INSERT_SORTED:
            begin
                at = int'(op.position);
                if (op.kind == K_INSERT_SORTED)
                begin
                    // goes in front of the first entry not below the value
                    at = 0;
                    while (at < list_len && op.item_value > list_vals[IDX_W'(at)])
                        at++;
                end
                if (at <= list_len && list_len < room)
                begin
                    for (i = list_len; i > at; i--)
                        list_vals[IDX_W'(i)] = list_vals[IDX_W'(i-1)];
                    list_vals[IDX_W'(at)] = op.item_value;
                    list_len++;
                    r.ok           = 1'b1;
                    r.result_index = IDX_W'(at);
                end
            end
            K_ERASE:
            begin
                if (int'(op.position) < list_len)
                begin
                    for (i = int'(op.position); i + 1 < list_len; i++)
                        list_vals[IDX_W'(i)] = list_vals[IDX_W'(i+1)];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            K_REMOVE_ALL:
            begin
                keep = 0;
                for (i = 0; i < list_len; i++)
                begin
                    if (list_vals[IDX_W'(i)] != op.item_value)
                    begin
                        list_vals[IDX_W'(keep)] = list_vals[IDX_W'(i)];
                        keep++;
                    end
                end
                r.removed_count = CNT_W'(list_len - keep);
                list_len = keep;
                r.ok = 1'b1;
            end
            K_FIND:
            begin
                for (i = 0; i < list_len; i++)
                begin
                    if (list_vals[IDX_W'(i)] == op.item_value)
                    begin
                        r.ok           = 1'b1;
                        r.result_index = IDX_W'(i);
                        break;
                    end
                end
            end
            K_GET:
            begin
                if (int'(op.position) < list_len)
                begin
                    r.read_value = list_vals[op.position[IDX_W-1:0]];
                    r.ok         = 1'b1;
                end
            end
            K_SET:
            begin
                if (int'(op.position) < list_len)
                begin
                    list_vals[op.position[IDX_W-1:0]] = op.item_value;
                    r.ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.entry_count = CNT_W'(list_len);
        return r;
    endfunction

    // mostly back to back, some short waits, a few long ones
    function automatic int pick_pause(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    task automatic queue_op(kind_t k, int pos, logic [ITEM_W-1:0] v);
        list_op_t op;
        op.kind       = k;
        op.position   = POS_W'(pos);
        op.item_value = v;
        op.hold_first = 1'b0;
        pending_ops.push_back(op);
    endtask

    task automatic queue_random(int n, int insert_pct);
        list_op_t op;
        int       r;
        int       k;
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < insert_pct)
                op.kind = $urandom_range(0, 1) ? K_INSERT_SORTED : K_INSERT_AT;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 18)
                    op.kind = K_ERASE;
                else if (r < 26)
                    op.kind = K_REMOVE_ALL;
                else if (r < 46)
                    op.kind = K_FIND;
                else if (r < 70)
                    op.kind = K_GET;
                else if (r < 94)
                    op.kind = K_SET;
                else
                    op.kind = K_NOP;
            end
            r = $urandom_range(0, 99);
            if (r < 50)
                op.position = POS_W'($urandom_range(0, 7));
            else if (r < 85)
                op.position = POS_W'($urandom_range(0, DEF_CAPACITY));
            else
                op.position = POS_W'($urandom_range(0, LOOK_N - 1));
            // a small pool of values so that finds hit and duplicates pile up
            r = $urandom_range(0, 99);
            if (r < 45)
                op.item_value = ITEM_W'($urandom_range(0, 7));
            else if (r < 55)
                op.item_value = $urandom_range(0, 1) ? '1 : '0;
            else
                op.item_value = $urandom();
            op.hold_first = ($urandom_range(0, 99) == 0);
            pending_ops.push_back(op);
        end
    endtask

    task automatic wait_idle();
        while (pending_ops.size() > 0 || req_if.valid || due_results.size() > 0)
            @(posedge clk);
    endtask

    // write the limit, then read it back
    task automatic write_limit(logic [LIMIT_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_LIMIT_IDX, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        limit_val = int'(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[LIMIT_W-1:0] !== value)
        begin
            $error("capacity_limit: expected %0h, got %0h", value, prdata[LIMIT_W-1:0]);
            mismatch_n++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic compare_field(string name, logic [ITEM_W-1:0] want, logic [ITEM_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_n++;
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
                due_results.push_back(apply_list_op(cur_op));
            if (!req_if.valid || req_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end
                else if (pending_ops.size() > 0 &&
                         !(pending_ops[0].hold_first && due_results.size() > 0))
                begin
                    cur_op = pending_ops.pop_front();
                    req_if.valid      <= 1'b1;
                    req_if.kind       <= cur_op.kind;
                    req_if.position   <= cur_op.position;
                    req_if.item_value <= cur_op.item_value;
                    gap_left = pick_pause(drive_burst);
                    if ($urandom_range(0, 59) == 0)
                        drive_burst = !drive_burst;
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result beat with nothing outstanding");
                    mismatch_n++;
                end
                else
                begin
                    list_result_t want;
                    want = due_results.pop_front();
                    compare_field("ok", ITEM_W'(want.ok), ITEM_W'(rsp_if.ok));
                    compare_field("result_index", ITEM_W'(want.result_index),
                                  ITEM_W'(rsp_if.result_index));
                    compare_field("removed_count", ITEM_W'(want.removed_count),
                                  ITEM_W'(rsp_if.removed_count));
                    compare_field("read_value", want.read_value, rsp_if.read_value);
                    compare_field("entry_count", ITEM_W'(want.entry_count),
                                  ITEM_W'(rsp_if.entry_count));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                stall_left = pick_pause(take_burst);
            end
            if ($urandom_range(0, 63) == 0)
                take_burst = !take_burst;
        end
    end

    always @(posedge clk)
    begin
        cycle_n++;
        if (cycle_n > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_if.valid      = 1'b0;
        req_if.kind       = '0;
        req_if.position   = '0;
        req_if.item_value = '0;
        rsp_if.ready      = 1'b0;
        list_len          = 0;
        limit_val         = int'(LIMIT_RESET);
        mismatch_n        = 0;
        cycle_n           = 0;
        gap_left          = 0;
        stall_left        = 0;
        drive_burst       = 1'b0;
        take_burst        = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // empty list, bad positions, duplicates and extremes
        queue_op(K_GET, 0, '0);
        queue_op(K_ERASE, 0, '0);
        queue_op(K_SET, 0, '1);
        queue_op(K_FIND, 0, '0);
        queue_op(K_REMOVE_ALL, 0, '0);
        queue_op(K_INSERT_AT, 1, 32'd5);
        queue_op(K_INSERT_AT, 0, '0);
        queue_op(K_INSERT_AT, 1, '1);
        queue_op(K_INSERT_SORTED, 0, 32'h8000_0000);
        queue_op(K_INSERT_SORTED, 0, '0);
        queue_op(K_INSERT_SORTED, 0, '1);
        queue_op(K_INSERT_AT, LOOK_N - 1, 32'd7);
        queue_op(K_FIND, 0, '1);
        queue_op(K_FIND, 0, 32'h1234_5678);
        queue_op(K_GET, 2, '0);
        queue_op(K_GET, LOOK_N - 1, '0);
        queue_op(K_SET, 2, 32'h5555_aaaa);
        queue_op(K_SET, 5, 32'd1);
        queue_op(K_GET, 2, '0);
        queue_op(K_REMOVE_ALL, 0, '0);
        queue_op(K_REMOVE_ALL, 0, '1);
        queue_op(K_ERASE, 0, '0);
        queue_op(K_ERASE, 0, '0);
        queue_op(K_NOP, LOOK_N - 1, '1);
        wait_idle();

        // limit above capacity saturates; fill the list up
        write_limit(LIMIT_W'(63));
        queue_random(150, 70);
        wait_idle();

        // limit dropped below the current count
        write_limit(LIMIT_W'(4));
        queue_random(60, 30);
        wait_idle();

        write_limit(LIMIT_W'(0));
        queue_random(30, 50);
        wait_idle();

        write_limit(LIMIT_W'(1));
        queue_random(40, 50);
        wait_idle();

        write_limit(LIMIT_W'(32));
        queue_random(75, 60);
        // sender holds off until the pipeline has drained
        pending_ops[pending_ops.size()-1].hold_first = 1'b1;
        queue_random(75, 45);
        wait_idle();

        write_limit(LIMIT_W'(17));
        queue_random(70, 55);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_n == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
